### rtl/core/lbfl_pkg.sv
`default_nettype none

package lbfl_pkg;

  // Width of the good-run and fail counters.
  localparam int COUNT_WIDTH = 8;
  localparam int THR_WIDTH   = 8;
  localparam int LEVEL_WIDTH = 8;
  localparam int CFG_IDX_WIDTH = 2;

  // Compares run at the wider of counter and threshold width.
  localparam int CMP_WIDTH = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;
  // Fail count is widened to at least the level width before the low bits are taken.
  localparam int EXT_WIDTH = (COUNT_WIDTH > LEVEL_WIDTH) ? COUNT_WIDTH : LEVEL_WIDTH;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [THR_WIDTH-1:0]   thr_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_FAULT_THR = 2'd0,
    CFG_CLEAR_THR = 2'd1,
    CFG_DECAY_THR = 2'd2
  } cfg_idx_t;

  localparam thr_t FAULT_THR_RST = 8'd5;
  localparam thr_t CLEAR_THR_RST = 8'd5;
  localparam thr_t DECAY_THR_RST = 8'd3;

  typedef struct packed {
    thr_t fault_thr;
    thr_t clear_thr;
    thr_t decay_thr;
  } cfg_t;

  typedef struct packed {
    logic                   fault_cleared;
    logic                   fault_active;
    logic [LEVEL_WIDTH-1:0] fail_level;
  } result_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == CNT_MAX) ? v : v + count_t'(1);
  endfunction

  function automatic logic ge_thr(input count_t v, input thr_t thr);
    return CMP_WIDTH'(v) >= CMP_WIDTH'(thr);
  endfunction

endpackage

`default_nettype wire

### rtl/core/leaky_bucket_fault_latch.sv
`default_nettype none
// A result is registered into the result queue when its read is accepted.
// Throughput: one read per cycle while the result queue has room; the counter update is a single pass of compare logic.
// A two-entry result queue keeps input accepting while one result waits downstream.
// Reset (rst, synchronous, active high) zeroes both counters, clears the fault,
// empties the result queue and restores thresholds to 5, 5 and 3.

module leaky_bucket_fault_latch
  import lbfl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [THR_WIDTH-1:0]     cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     read_good,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          fault_cleared,
  output logic                          fault_active,
  output logic [LEVEL_WIDTH-1:0]        fail_level
);

  cfg_t    cfg;
  result_t step_result;
  result_t head;
  logic    in_fire;
  logic    out_fire;

  // A transaction on either channel happens when valid and ready meet.
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Threshold registers; the user must write them only while the block is idle, as the block does not enforce it.
  lbfl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The counters and the fault flag advance on every accepted read, and the
  // result of that read is computed in the same pass from the next state.
  lbfl_state u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (in_fire),
    .read_good (read_good),
    .cfg       (cfg),
    .result    (step_result)
  );

  // The result queue holds up to two finished results, so a stalled output
  // does not stop the next read from being taken until both entries are full.
  lbfl_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (step_result),
    .can_push  (in_ready),
    .pop       (out_fire),
    .has_data  (out_valid),
    .head      (head)
  );

  assign fault_cleared = head.fault_cleared;
  assign fault_active  = head.fault_active;
  assign fail_level    = head.fail_level;

  // An accepted read always leaves a result pending in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted read produced no pending result");

  // Input is held off only while results are waiting.
  a_stall_means_pending: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty result queue");

  // A clearing read leaves the fault down and the fail count at zero.
  a_clear_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault_cleared) |-> (!fault_active && (fail_level == '0)))
    else $error("cleared result with fault or fail count still set");

  // Reset empties the result queue.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule

`default_nettype wire

### rtl/core/lbfl_cfg_regs.sv
`default_nettype none

module lbfl_cfg_regs
  import lbfl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [THR_WIDTH-1:0]     cfg_data,
  output cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fault_thr <= FAULT_THR_RST;
      cfg.clear_thr <= CLEAR_THR_RST;
      cfg.decay_thr <= DECAY_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAULT_THR: cfg.fault_thr <= cfg_data;
        CFG_CLEAR_THR: cfg.clear_thr <= cfg_data;
        CFG_DECAY_THR: cfg.decay_thr <= cfg_data;
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/lbfl_state.sv
`default_nettype none

module lbfl_state
  import lbfl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire logic  read_good,
  input  wire cfg_t  cfg,
  output result_t    result
);

  count_t good_run, good_run_next;
  count_t fail_count, fail_count_next;
  logic   fault_latched, fault_latched_next;
  logic   cleared;
  logic [EXT_WIDTH-1:0] fail_ext;

  always_comb begin
    good_run_next      = good_run;
    fail_count_next    = fail_count;
    fault_latched_next = fault_latched;
    cleared            = 1'b0;
    if (read_good) begin
      good_run_next = sat_inc(good_run);
      if (fault_latched) begin
        if (ge_thr(good_run_next, cfg.clear_thr)) begin
          fault_latched_next = 1'b0;
          fail_count_next    = '0;
          cleared            = 1'b1;
        end
      end else if (ge_thr(good_run_next, cfg.decay_thr) && (fail_count != '0)) begin
        fail_count_next = fail_count - count_t'(1);
      end
    end else begin
      good_run_next   = '0;
      fail_count_next = sat_inc(fail_count);
      if (ge_thr(fail_count_next, cfg.fault_thr)) begin
        fault_latched_next = 1'b1;
      end
    end
  end

  assign fail_ext = EXT_WIDTH'(fail_count_next);

  assign result.fault_cleared = cleared;
  assign result.fault_active  = fault_latched_next;
  assign result.fail_level    = fail_ext[LEVEL_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      good_run      <= '0;
      fail_count    <= '0;
      fault_latched <= 1'b0;
    end else if (step) begin
      good_run      <= good_run_next;
      fail_count    <= fail_count_next;
      fault_latched <= fault_latched_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lbfl_out_queue.sv
`default_nettype none

module lbfl_out_queue
  import lbfl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         can_push,
  input  wire logic    pop,
  output logic         has_data,
  output result_t      head
);

  result_t     entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign can_push = (count != 2'd2);
  assign has_data = (count != 2'd0);
  assign head     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sim/tb_leaky_bucket_fault_latch.sv
`default_nettype none

module tb_leaky_bucket_fault_latch;
  import lbfl_pkg::*;

  // The two-bit index field has one code with no register behind it.
  // A write to that code must leave every threshold alone.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [THR_WIDTH-1:0]     cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     read_good = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     fault_cleared;
  logic                     fault_active;
  logic [LEVEL_WIDTH-1:0]   fail_level;

  leaky_bucket_fault_latch u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .read_good    (read_good),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fault_cleared(fault_cleared),
    .fault_active (fault_active),
    .fail_level   (fail_level)
  );

  always #5 clk = ~clk;

  // Sensor reads waiting to be offered, and the reports each accepted read
  // should produce, oldest first.
  bit      pending_reads[$];
  result_t expected_reports[$];

  // Our own copy of the fault logic: thresholds, run and fail counters, latch.
  cfg_t   cfg_m = '{fault_thr: FAULT_THR_RST, clear_thr: CLEAR_THR_RST,
                    decay_thr: DECAY_THR_RST};
  count_t run_len = '0;
  count_t fail_cnt_m = '0;
  logic   fault_latched_m = 1'b0;

  // Traffic shaping: chance in percent that the sender holds back a
  // transaction in a cycle, and that the receiver refuses one.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  int mismatch_total = 0;
  int reads_accepted = 0;
  int settings_used = 1;
  int latches_seen = 0;
  int clears_seen = 0;
  int cycle_count = 0;
  result_t oldest_report;

  // Applies one read to the local copy of the latch and queues the report
  // the block should return for it.
  function automatic void advance_fault_state(input logic good);
    result_t rpt;
    rpt.fault_cleared = 1'b0;
    if (good) begin
      if (run_len != CNT_MAX) run_len = run_len + 1'b1;
      if (fault_latched_m) begin
        if (int'(run_len) >= int'(cfg_m.clear_thr)) begin
          fault_latched_m = 1'b0;
          fail_cnt_m = '0;
          rpt.fault_cleared = 1'b1;
          clears_seen++;
        end
      end else if (int'(run_len) >= int'(cfg_m.decay_thr) && fail_cnt_m != '0) begin
        fail_cnt_m = fail_cnt_m - 1'b1;
      end
    end else begin
      run_len = '0;
      if (fail_cnt_m != CNT_MAX) fail_cnt_m = fail_cnt_m + 1'b1;
      if (int'(fail_cnt_m) >= int'(cfg_m.fault_thr)) begin
        if (!fault_latched_m) latches_seen++;
        fault_latched_m = 1'b1;
      end
    end
    rpt.fault_active = fault_latched_m;
    rpt.fail_level = LEVEL_WIDTH'(fail_cnt_m);
    expected_reports.push_back(rpt);
  endfunction

  function automatic bit roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Driver. A read is predicted at the edge where its transaction is
  // accepted. A new read is only offered once the previous one is gone, so
  // valid holds steady with its payload while the block back-pressures.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      read_good <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_fault_state(read_good);
        reads_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reads.size() > 0 && !roll(send_gap_pct)) begin
          in_valid <= 1'b1;
          read_good <= pending_reads.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted report is compared field by field with the
  // oldest prediction; ready is re-rolled every cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("report with no read pending: fault_cleared=%0b fault_active=%0b fail_level=%0d",
                 fault_cleared, fault_active, fail_level);
          mismatch_total++;
        end else begin
          oldest_report = expected_reports.pop_front();
          if (fault_cleared !== oldest_report.fault_cleared) begin
            $error("fault_cleared: expected %0b, got %0b", oldest_report.fault_cleared,
                   fault_cleared);
            mismatch_total++;
          end
          if (fault_active !== oldest_report.fault_active) begin
            $error("fault_active: expected %0b, got %0b", oldest_report.fault_active,
                   fault_active);
            mismatch_total++;
          end
          if (fail_level !== oldest_report.fail_level) begin
            $error("fail_level: expected %0d, got %0d", oldest_report.fail_level, fail_level);
            mismatch_total++;
          end
        end
      end
      out_ready <= !roll(recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake must not let the run go on forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("leaky_bucket_fault_latch verification failed");
      $finish;
    end
  end

  // Writes one register and mirrors it into the local copy. Only called
  // while no transaction is in flight, so the mirror can update at once.
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input thr_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FAULT_THR: cfg_m.fault_thr = val;
      CFG_CLEAR_THR: cfg_m.clear_thr = val;
      CFG_DECAY_THR: cfg_m.decay_thr = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input thr_t fault_thr, input thr_t clear_thr,
                                input thr_t decay_thr);
    write_reg(CFG_FAULT_THR, fault_thr);
    write_reg(CFG_CLEAR_THR, clear_thr);
    write_reg(CFG_DECAY_THR, decay_thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Waits until every read has been offered, accepted and answered before
  // touching the registers again.
  task automatic wait_idle();
    while (pending_reads.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_run(input bit good, input int len);
    repeat (len) pending_reads.push_back(good);
  endtask

  // Random traffic as runs of good or bad reads. Runs are what move the
  // counters past their thresholds; single flips in between act as noise.
  task automatic queue_bursts(input int n_reads);
    int added;
    int len;
    added = 0;
    while (added < n_reads) begin
      len = roll(20) ? 1 : $urandom_range(12, 2);
      queue_run(bit'($urandom_range(1, 0)), len);
      added += len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // The unused index must be ignored; the reset thresholds 5, 5 and 3
    // then govern the directed sequence below.
    write_reg(CFG_IDX_UNUSED, 8'd1);
    @(posedge clk);
    cfg_we <= 1'b0;

    // Latch after five fails, a bad read while latched, a broken good run,
    // a clear on the fifth good read, good reads with nothing to forgive,
    // then decay starting at the third good read.
    queue_run(1'b0, 6);
    queue_run(1'b1, 4);
    queue_run(1'b0, 1);
    queue_run(1'b1, 7);
    queue_run(1'b0, 2);
    queue_run(1'b1, 4);
    wait_idle();

    // Zero thresholds: any bad read latches, any good read clears.
    set_thresholds(8'd0, 8'd0, 8'd0);
    queue_bursts(20);
    wait_idle();

    // Saturation of both counters with the largest thresholds. The fail
    // count pins at its maximum and latches there; later the good run must
    // hold at its maximum so that decay keeps going past it.
    set_thresholds(8'd255, 8'd1, 8'd255);
    send_gap_pct = 38;
    recv_stall_pct = 38;
    queue_run(1'b0, 258);
    queue_run(1'b1, 1);
    queue_run(1'b0, 3);
    queue_run(1'b1, 258);
    wait_idle();

    // Small random thresholds under each traffic pattern, so faults latch
    // and clear often with gaps landing on every stage of the handshake.
    for (int phase = 0; phase < 4; phase++) begin
      set_thresholds(thr_t'($urandom_range(8, 1)), thr_t'($urandom_range(8, 1)),
                     thr_t'($urandom_range(6, 1)));
      send_gap_pct = (phase == 1) ? 86 : (phase == 3) ? 38 : 0;
      recv_stall_pct = (phase == 2) ? 86 : (phase == 3) ? 38 : 0;
      queue_bursts(15);
      wait_idle();
    end

    // Opposite extremes: latch on the first fail, almost never clear.
    set_thresholds(8'd1, 8'd255, 8'd1);
    send_gap_pct = 0;
    recv_stall_pct = 86;
    queue_bursts(15);
    wait_idle();

    repeat (8) @(posedge clk);
    $display("Checked %0d sensor reads across %0d threshold settings and four traffic patterns.",
             reads_accepted, settings_used);
    $display("The fault latched %0d times and was cleared %0d times.", latches_seen,
             clears_seen);
    if (mismatch_total == 0) begin
      $display("leaky_bucket_fault_latch verification clean");
    end else begin
      $display("leaky_bucket_fault_latch verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### leaky_bucket_fault_latch.f
rtl/core/lbfl_pkg.sv
rtl/core/lbfl_cfg_regs.sv
rtl/core/lbfl_state.sv
rtl/core/lbfl_out_queue.sv
rtl/core/leaky_bucket_fault_latch.sv
sim/tb_leaky_bucket_fault_latch.sv
